// File: hw/rtl/rca_pkg.sv
// ----------------------------------------------------------------------------
// rca_pkg: shared types and constants for the RGB color adjust unit
// Operation codes, register indexes, queue entry and configuration structs,
// fixed-point weights.
// ----------------------------------------------------------------------------
package rca_pkg;

    localparam int unsigned CHAN_W          = 8;
    localparam int unsigned NUM_CHAN        = 3;
    localparam int unsigned CFG_DATA_W      = 12;
    localparam int unsigned CFG_INDEX_W     = 2;
    localparam int unsigned GAIN_W          = 12;
    localparam int unsigned OFFSET_W        = 9;
    localparam int unsigned COEF_W          = 16;
    localparam int unsigned GAMMA_DEPTH     = 256;
    localparam int unsigned QUEUE_DEPTH_DEF = 4;

    // contrast pivot 128 in Q.8, added after the gain multiply
    localparam int unsigned CONTRAST_BIAS   = 32768;
    localparam int unsigned CONTRAST_FRAC   = 8;

    typedef enum logic [2:0] {
        MODE_BRIGHTNESS = 3'd0,
        MODE_CONTRAST   = 3'd1,
        MODE_GRAYSCALE  = 3'd2,
        MODE_SEPIA      = 3'd3,
        MODE_INVERT     = 3'd4,
        MODE_THRESHOLD  = 3'd5,
        MODE_GAMMA      = 3'd6
    } mode_t;

    typedef enum logic {
        CMD_PIXEL       = 1'b0,
        CMD_TABLE_WRITE = 1'b1
    } cmd_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MODE       = 2'd0,
        CFG_BRIGHTNESS = 2'd1,
        CFG_CONTRAST   = 2'd2,
        CFG_THRESHOLD  = 2'd3
    } cfg_index_t;

    localparam mode_t              MODE_RESET      = MODE_BRIGHTNESS;
    localparam logic [GAIN_W-1:0]  GAIN_RESET      = 12'd256;
    localparam logic [CHAN_W-1:0]  THRESHOLD_RESET = 8'd128;

    // luma weights, Q0.16, order r g b
    localparam logic [COEF_W-1:0] GRAY_COEF [NUM_CHAN] = '{16'd19595, 16'd38470, 16'd7471};

    // sepia matrix, Q0.16, [output channel][input channel]
    localparam logic [COEF_W-1:0] SEPIA_COEF [NUM_CHAN][NUM_CHAN] = '{
        '{16'd25756, 16'd50397, 16'd12386},
        '{16'd22872, 16'd44958, 16'd11010},
        '{16'd17826, 16'd34996, 16'd8585}
    };

    typedef struct packed {
        mode_t                       mode;
        logic signed [OFFSET_W-1:0]  brightness_offset;
        logic        [GAIN_W-1:0]    contrast_gain;
        logic        [CHAN_W-1:0]    threshold_level;
    } cfg_t;

    // table writes reuse red as index and green as value
    typedef struct packed {
        cmd_t              cmd;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic              frame_end;
    } entry_t;

endpackage

// File: hw/rtl/rca_ram.sv
// ----------------------------------------------------------------------------
// rca_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data and read enable.
// ----------------------------------------------------------------------------
module rca_ram #(
    parameter  int unsigned WIDTH  = 8,
    parameter  int unsigned DEPTH  = 256,
    localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hw/rtl/rca_fifo.sv
// ----------------------------------------------------------------------------
// rca_fifo: short queue between front and back
// Register-based circular buffer, push and pop in the same cycle allowed.
// ----------------------------------------------------------------------------
module rca_fifo #(
    parameter int unsigned DEPTH = rca_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push_valid,
    output logic            push_ready,
    input  rca_pkg::entry_t push_data,
    output logic            pop_valid,
    input  logic            pop_ready,
    output rca_pkg::entry_t pop_data
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    rca_pkg::entry_t  slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    // occupancy and pointers must agree
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count above depth");

    a_empty_ptrs: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with split pointers");

    a_full_ptrs: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == CNT_W'(DEPTH)) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("full queue with split pointers");

endmodule

// File: hw/rtl/rca_front.sv
// ----------------------------------------------------------------------------
// rca_front: configuration registers and input classification
// Holds the mode/offset/gain/threshold registers and packs each input item
// into a queue entry, folding table-write index/value into the pixel slots.
// ----------------------------------------------------------------------------
module rca_front (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [rca_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [rca_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    output rca_pkg::cfg_t                      cfg,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_cmd,
    input  logic [rca_pkg::CHAN_W-1:0]         s_red,
    input  logic [rca_pkg::CHAN_W-1:0]         s_green,
    input  logic [rca_pkg::CHAN_W-1:0]         s_blue,
    input  logic [rca_pkg::CHAN_W-1:0]         s_table_index,
    input  logic [rca_pkg::CHAN_W-1:0]         s_table_value,
    input  logic                               s_frame_end,
    output logic                               q_valid,
    input  logic                               q_ready,
    output rca_pkg::entry_t                    q_data
);

    rca_pkg::cfg_t cfg_reg, cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (rca_pkg::cfg_index_t'(cfg_index))
                rca_pkg::CFG_MODE: begin
                    cfg_next.mode = rca_pkg::mode_t'(cfg_wdata[2:0]);
                end
                rca_pkg::CFG_BRIGHTNESS: begin
                    cfg_next.brightness_offset = $signed(cfg_wdata[rca_pkg::OFFSET_W-1:0]);
                end
                rca_pkg::CFG_CONTRAST: begin
                    cfg_next.contrast_gain = cfg_wdata[rca_pkg::GAIN_W-1:0];
                end
                rca_pkg::CFG_THRESHOLD: begin
                    cfg_next.threshold_level = cfg_wdata[rca_pkg::CHAN_W-1:0];
                end
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mode              <= rca_pkg::MODE_RESET;
            cfg_reg.brightness_offset <= '0;
            cfg_reg.contrast_gain     <= rca_pkg::GAIN_RESET;
            cfg_reg.threshold_level   <= rca_pkg::THRESHOLD_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

    // classify: table writes carry index in red, value in green
    always_comb begin
        q_data.cmd       = rca_pkg::cmd_t'(s_cmd);
        q_data.frame_end = s_frame_end;
        q_data.blue      = s_blue;
        if (rca_pkg::cmd_t'(s_cmd) == rca_pkg::CMD_TABLE_WRITE) begin
            q_data.red   = s_table_index;
            q_data.green = s_table_value;
        end else begin
            q_data.red   = s_red;
            q_data.green = s_green;
        end
    end

    assign q_valid = s_valid;
    assign s_ready = q_ready;

endmodule

// File: hw/rtl/rca_back.sv
// ----------------------------------------------------------------------------
// rca_back: execution pipeline
// Pops queue entries in order: table writes update the gamma RAMs, pixels go
// through lookup/simple ops, product stage, final sum/saturate and output.
// ----------------------------------------------------------------------------
module rca_back (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  rca_pkg::cfg_t              cfg,
    input  logic                       q_valid,
    output logic                       q_ready,
    input  rca_pkg::entry_t            q_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [rca_pkg::CHAN_W-1:0] m_red_out,
    output logic [rca_pkg::CHAN_W-1:0] m_green_out,
    output logic [rca_pkg::CHAN_W-1:0] m_blue_out,
    output logic                       m_frame_end_out
);

    localparam int unsigned CW     = rca_pkg::CHAN_W;
    localparam int unsigned NCH    = rca_pkg::NUM_CHAN;
    localparam int unsigned PROD_W = rca_pkg::COEF_W + CW;
    localparam int unsigned ACC_W  = PROD_W + 2;
    localparam int unsigned GS_W   = rca_pkg::GAIN_W + 1;
    localparam int unsigned CON_W  = CW + GS_W;
    localparam int unsigned BW     = CW + 2;
    localparam int unsigned FR     = rca_pkg::CONTRAST_FRAC;

    function automatic logic [CW-1:0] sat_q16(input logic [ACC_W-1:0] acc);
        return (acc[ACC_W-1:PROD_W] != '0) ? {CW{1'b1}} : acc[PROD_W-1:PROD_W-CW];
    endfunction

    function automatic logic [CW-1:0] contrast_fin(input logic signed [CON_W-1:0] prod);
        logic signed [CON_W-1:0] s;
        s = prod + CON_W'(rca_pkg::CONTRAST_BIAS);
        if (s[CON_W-1]) begin
            return '0;
        end else if (s[CON_W-2:FR+CW] != '0) begin
            return {CW{1'b1}};
        end else begin
            return s[FR+CW-1:FR];
        end
    endfunction

    logic adv, pop, tbl_wr, s1_valid_next;
    logic [CW-1:0] pop_chan [NCH];
    logic [CW-1:0] gamma_rd [NCH];

    // stage 1: pixel and gamma read data
    logic          s1_valid_reg;
    logic [CW-1:0] s1_chan_reg [NCH];
    logic          s1_fe_reg;

    // stage 2: simple results and products
    logic                     s2_valid_reg;
    logic                     s2_fe_reg;
    logic [CW-1:0]            s2_simple_reg [NCH];
    logic signed [CON_W-1:0]  s2_con_reg    [NCH];
    logic [PROD_W-1:0]        s2_gray_reg   [NCH];
    logic [PROD_W-1:0]        s2_sep_reg    [NCH][NCH];

    // output register
    logic          out_valid_reg;
    logic [CW-1:0] out_chan_reg [NCH];
    logic          out_fe_reg;

    // stage 1 combinational
    logic [CW-1:0]            simple_next   [NCH];
    logic signed [CON_W-1:0]  con_next      [NCH];
    logic [PROD_W-1:0]        gray_next     [NCH];
    logic [PROD_W-1:0]        sep_next      [NCH][NCH];
    logic signed [BW-1:0]     bsum          [NCH];
    logic signed [CW-1:0]     dev           [NCH];
    logic signed [GS_W-1:0]   gain_s;
    logic [BW-1:0]            chan_sum, thr3;
    logic                     white;

    // stage 2 combinational
    logic [ACC_W-1:0] gray_acc;
    logic [ACC_W-1:0] sep_acc [NCH];
    logic [CW-1:0]    out_next [NCH];

    assign adv           = !out_valid_reg || m_ready;
    assign q_ready       = adv;
    assign pop           = q_valid && adv;
    assign tbl_wr        = pop && (q_data.cmd == rca_pkg::CMD_TABLE_WRITE);
    assign s1_valid_next = pop && (q_data.cmd == rca_pkg::CMD_PIXEL);

    assign pop_chan[0] = q_data.red;
    assign pop_chan[1] = q_data.green;
    assign pop_chan[2] = q_data.blue;

    // one gamma copy per channel so all three lookups happen together
    for (genvar i = 0; i < NCH; i++) begin : g_gamma
        rca_ram #(
            .WIDTH (CW),
            .DEPTH (rca_pkg::GAMMA_DEPTH)
        ) u_gamma_ram (
            .aclk    (aclk),
            .wr_en   (tbl_wr),
            .wr_addr (q_data.red),
            .wr_data (q_data.green),
            .rd_en   (adv),
            .rd_addr (pop_chan[i]),
            .rd_data (gamma_rd[i])
        );
    end

    always_comb begin
        gain_s   = $signed({1'b0, cfg.contrast_gain});
        chan_sum = BW'(s1_chan_reg[0]) + BW'(s1_chan_reg[1]) + BW'(s1_chan_reg[2]);
        // floor(sum/3) >= T  <=>  sum >= 3T
        thr3     = (BW'(cfg.threshold_level) << 1) + BW'(cfg.threshold_level);
        white    = (chan_sum >= thr3);
        for (int i = 0; i < NCH; i++) begin
            bsum[i] = $signed({2'b00, s1_chan_reg[i]}) + BW'(cfg.brightness_offset);
            dev[i]  = $signed({~s1_chan_reg[i][CW-1], s1_chan_reg[i][CW-2:0]});
            con_next[i]  = CON_W'(dev[i]) * CON_W'(gain_s);
            gray_next[i] = PROD_W'(rca_pkg::GRAY_COEF[i]) * PROD_W'(s1_chan_reg[i]);
            for (int j = 0; j < NCH; j++) begin
                sep_next[j][i] = PROD_W'(rca_pkg::SEPIA_COEF[j][i]) * PROD_W'(s1_chan_reg[i]);
            end
            case (cfg.mode)
                rca_pkg::MODE_BRIGHTNESS: begin
                    if (bsum[i][BW-1]) begin
                        simple_next[i] = '0;
                    end else if (bsum[i][BW-2]) begin
                        simple_next[i] = {CW{1'b1}};
                    end else begin
                        simple_next[i] = bsum[i][CW-1:0];
                    end
                end
                rca_pkg::MODE_INVERT:    simple_next[i] = ~s1_chan_reg[i];
                rca_pkg::MODE_THRESHOLD: simple_next[i] = white ? {CW{1'b1}} : '0;
                rca_pkg::MODE_GAMMA:     simple_next[i] = gamma_rd[i];
                default:                 simple_next[i] = s1_chan_reg[i];
            endcase
        end
    end

    always_comb begin
        gray_acc = ACC_W'(s2_gray_reg[0]) + ACC_W'(s2_gray_reg[1]) + ACC_W'(s2_gray_reg[2]);
        for (int j = 0; j < NCH; j++) begin
            sep_acc[j] = ACC_W'(s2_sep_reg[j][0]) + ACC_W'(s2_sep_reg[j][1])
                       + ACC_W'(s2_sep_reg[j][2]);
            case (cfg.mode)
                rca_pkg::MODE_CONTRAST:  out_next[j] = contrast_fin(s2_con_reg[j]);
                rca_pkg::MODE_GRAYSCALE: out_next[j] = sat_q16(gray_acc);
                rca_pkg::MODE_SEPIA:     out_next[j] = sat_q16(sep_acc[j]);
                default:                 out_next[j] = s2_simple_reg[j];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_fe_reg  <= q_data.frame_end;
            s2_fe_reg  <= s1_fe_reg;
            out_fe_reg <= s2_fe_reg;
            for (int i = 0; i < NCH; i++) begin
                s1_chan_reg[i]   <= pop_chan[i];
                s2_simple_reg[i] <= simple_next[i];
                s2_con_reg[i]    <= con_next[i];
                s2_gray_reg[i]   <= gray_next[i];
                out_chan_reg[i]  <= out_next[i];
                for (int j = 0; j < NCH; j++) begin
                    s2_sep_reg[j][i] <= sep_next[j][i];
                end
            end
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_red_out       = out_chan_reg[0];
    assign m_green_out     = out_chan_reg[1];
    assign m_blue_out      = out_chan_reg[2];
    assign m_frame_end_out = out_fe_reg;

    a_tbl_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        tbl_wr |=> !s1_valid_reg)
        else $error("table write entered the pixel pipeline");

    a_pix_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && q_data.cmd == rca_pkg::CMD_PIXEL) |=> s1_valid_reg)
        else $error("popped pixel lost");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready) |=> $stable(s2_valid_reg) && $stable(s1_valid_reg))
        else $error("pipeline moved while output stalled");

endmodule

// File: hw/rtl/rgb_color_adjust_unit.sv
// ----------------------------------------------------------------------------
// rgb_color_adjust_unit: per-pixel RGB point operations
// Front (config + classify), short queue, back (gamma RAMs + pipeline).
// ----------------------------------------------------------------------------
// One item per cycle sustained, pixels and gamma table writes alike, while no
// result waits on a low m_ready. Input transfers land in a QUEUE_DEPTH-entry
// queue; the back end pops one entry per cycle unless its output stalls. A
// pixel goes from the queue through the gamma lookup stage, the product
// stage and the output register (sum, saturate, mode select) to m_valid.
// Table writes are applied to the gamma table when they leave the queue, in
// stream order with pixels, so a pixel always sees every table write that
// came before it and none after. Table writes produce no result. A result
// waiting on a low m_ready holds the back end; a full queue drops s_ready.
// The gamma table has no reset; a pixel in gamma mode must only index entries
// already written. Config registers (mode, brightness_offset, contrast_gain,
// threshold_level at indexes 0..3) take a write on every cycle cfg_wr_en is
// high and must only change while no items are in flight.
module rgb_color_adjust_unit #(
    parameter int unsigned QUEUE_DEPTH = rca_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration write port
    input  logic                            cfg_wr_en,
    input  logic [rca_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rca_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // input channel
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_cmd,
    input  logic [rca_pkg::CHAN_W-1:0]      s_red,
    input  logic [rca_pkg::CHAN_W-1:0]      s_green,
    input  logic [rca_pkg::CHAN_W-1:0]      s_blue,
    input  logic [rca_pkg::CHAN_W-1:0]      s_table_index,
    input  logic [rca_pkg::CHAN_W-1:0]      s_table_value,
    input  logic                            s_frame_end,
    // result channel
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [rca_pkg::CHAN_W-1:0]      m_red_out,
    output logic [rca_pkg::CHAN_W-1:0]      m_green_out,
    output logic [rca_pkg::CHAN_W-1:0]      m_blue_out,
    output logic                            m_frame_end_out
);

    rca_pkg::cfg_t   cfg;
    rca_pkg::entry_t fq_data;   // front -> queue
    rca_pkg::entry_t qb_data;   // queue -> back
    logic            fq_valid, fq_ready;
    logic            qb_valid, qb_ready;

    // config registers and item packing
    rca_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .cfg           (cfg),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_red         (s_red),
        .s_green       (s_green),
        .s_blue        (s_blue),
        .s_table_index (s_table_index),
        .s_table_value (s_table_value),
        .s_frame_end   (s_frame_end),
        .q_valid       (fq_valid),
        .q_ready       (fq_ready),
        .q_data        (fq_data)
    );

    // decouples the input transfer from back-end stalls
    rca_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_data  (fq_data),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_data   (qb_data)
    );

    // in-order execution: gamma table updates and the pixel pipeline
    rca_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg),
        .q_valid         (qb_valid),
        .q_ready         (qb_ready),
        .q_data          (qb_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_red_out       (m_red_out),
        .m_green_out     (m_green_out),
        .m_blue_out      (m_blue_out),
        .m_frame_end_out (m_frame_end_out)
    );

endmodule

// File: tb/rgb_color_adjust_unit_test.sv
// ----------------------------------------------------------------------------
// rgb_color_adjust_unit_test: self-checking bench for the RGB color adjust unit
// Drives pixels and gamma table writes over the input channel. A predictor in
// the bench computes each adjusted pixel at its input transfer, and a monitor
// compares every output transfer against the oldest pending prediction.
// ----------------------------------------------------------------------------
module rgb_color_adjust_unit_test;

    // mode 7 has no operation and passes the pixel through
    localparam logic [2:0] MODE_UNUSED = 3'd7;

    // idle cycles after the last pending pixel before the block counts as quiet;
    // covers table writes still sitting in the queue and the back pipeline
    localparam int SETTLE_CYCLES = rca_pkg::QUEUE_DEPTH_DEF + 8;

    // luma and sepia weights, Q0.16
    localparam int unsigned GRAY_W [3] = '{19595, 38470, 7471};
    localparam int unsigned SEPIA_W [3][3] = '{
        '{25756, 50397, 12386},
        '{22872, 44958, 11010},
        '{17826, 34996, 8585}
    };

    typedef struct {
        logic [rca_pkg::CHAN_W-1:0] red;
        logic [rca_pkg::CHAN_W-1:0] green;
        logic [rca_pkg::CHAN_W-1:0] blue;
        logic                       frame_end;
    } adjusted_pixel_t;

    // ------------------------------------------------------------------------
    // DUT ports
    // ------------------------------------------------------------------------
    logic                            aclk;
    logic                            aresetn;
    logic                            cfg_wr_en;
    logic [rca_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [rca_pkg::CFG_DATA_W-1:0]  cfg_wdata;
    logic                            s_valid;
    logic                            s_ready;
    logic                            s_cmd;
    logic [rca_pkg::CHAN_W-1:0]      s_red;
    logic [rca_pkg::CHAN_W-1:0]      s_green;
    logic [rca_pkg::CHAN_W-1:0]      s_blue;
    logic [rca_pkg::CHAN_W-1:0]      s_table_index;
    logic [rca_pkg::CHAN_W-1:0]      s_table_value;
    logic                            s_frame_end;
    logic                            m_valid;
    logic                            m_ready;
    logic [rca_pkg::CHAN_W-1:0]      m_red_out;
    logic [rca_pkg::CHAN_W-1:0]      m_green_out;
    logic [rca_pkg::CHAN_W-1:0]      m_blue_out;
    logic                            m_frame_end_out;

    rgb_color_adjust_unit dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cmd           (s_cmd),
        .s_red           (s_red),
        .s_green         (s_green),
        .s_blue          (s_blue),
        .s_table_index   (s_table_index),
        .s_table_value   (s_table_value),
        .s_frame_end     (s_frame_end),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_red_out       (m_red_out),
        .m_green_out     (m_green_out),
        .m_blue_out      (m_blue_out),
        .m_frame_end_out (m_frame_end_out)
    );

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    // Register copies start at their reset values; reset is applied only once.
    logic [2:0]                          cur_mode   = rca_pkg::MODE_BRIGHTNESS;
    logic signed [rca_pkg::OFFSET_W-1:0] cur_offset = '0;
    logic [rca_pkg::GAIN_W-1:0]          cur_gain   = 12'd256;
    logic [rca_pkg::CHAN_W-1:0]          cur_level  = 8'd128;

    // Gamma table copy; only entries flagged as written may be looked up.
    logic [rca_pkg::CHAN_W-1:0] gamma_copy [rca_pkg::GAMMA_DEPTH];
    bit                         gamma_written [rca_pkg::GAMMA_DEPTH];
    logic [rca_pkg::CHAN_W-1:0] written_entries [$];

    adjusted_pixel_t            pending_pixels [$];
    int                         mismatches;

    // traffic shaping: random idle bursts on each side, plus a long hold-off
    bit                         tx_gaps;
    bit                         rx_gaps;
    int                         hold_request;
    int                         hold_left;
    int                         stall_left;

    always #1 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic logic [rca_pkg::CHAN_W-1:0] clamp_chan(int v);
        if (v < 0) return 8'd0;
        if (v > 255) return 8'd255;
        return 8'(v);
    endfunction

    // truncate a Q0.16 weighted sum and saturate at white
    function automatic logic [rca_pkg::CHAN_W-1:0] q16_sat(int unsigned acc);
        int unsigned v;
        v = acc >> 16;
        return (v > 255) ? 8'd255 : 8'(v);
    endfunction

    function automatic adjusted_pixel_t adjust_pixel(logic [rca_pkg::CHAN_W-1:0] r,
                                                     logic [rca_pkg::CHAN_W-1:0] g,
                                                     logic [rca_pkg::CHAN_W-1:0] b,
                                                     logic fe);
        logic [rca_pkg::CHAN_W-1:0] chan [3];
        logic [rca_pkg::CHAN_W-1:0] outc [3];
        int                         level;
        int unsigned                acc;
        adjusted_pixel_t            res;
        chan = '{r, g, b};
        outc = chan;
        case (cur_mode)
            rca_pkg::MODE_BRIGHTNESS: begin
                foreach (chan[k]) outc[k] = clamp_chan(int'(chan[k]) + int'(cur_offset));
            end
            rca_pkg::MODE_CONTRAST: begin
                // pivot about 128, Q4.8 gain, negative sums go to black
                foreach (chan[k]) begin
                    level = (int'(chan[k]) - 128) * int'(cur_gain) + 32768;
                    outc[k] = (level < 0) ? 8'd0 : clamp_chan(level >>> 8);
                end
            end
            rca_pkg::MODE_GRAYSCALE: begin
                acc = GRAY_W[0] * chan[0] + GRAY_W[1] * chan[1] + GRAY_W[2] * chan[2];
                foreach (outc[k]) outc[k] = q16_sat(acc);
            end
            rca_pkg::MODE_SEPIA: begin
                foreach (outc[k]) begin
                    acc = SEPIA_W[k][0] * chan[0] + SEPIA_W[k][1] * chan[1]
                        + SEPIA_W[k][2] * chan[2];
                    outc[k] = q16_sat(acc);
                end
            end
            rca_pkg::MODE_INVERT: begin
                foreach (chan[k]) outc[k] = 8'd255 - chan[k];
            end
            rca_pkg::MODE_THRESHOLD: begin
                level = (int'(chan[0]) + int'(chan[1]) + int'(chan[2])) / 3;
                foreach (outc[k]) outc[k] = (level >= int'(cur_level)) ? 8'd255 : 8'd0;
            end
            rca_pkg::MODE_GAMMA: begin
                foreach (chan[k]) outc[k] = gamma_copy[chan[k]];
            end
            default: ;
        endcase
        res.red       = outc[0];
        res.green     = outc[1];
        res.blue      = outc[2];
        res.frame_end = fe;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Error reporting
    // ------------------------------------------------------------------------
    task automatic report_error(string msg);
        mismatches++;
        $display("ERROR @%0t: %s", $time, msg);
    endtask

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------
    // One transfer on the input channel. Valid goes high without looking at
    // ready and holds with a stable payload until the transfer. The prediction
    // (or the table copy update) happens at the transfer edge, so it sees the
    // same stream order as the block.
    task automatic send_item(rca_pkg::cmd_t cmd, logic [rca_pkg::CHAN_W-1:0] r,
                             logic [rca_pkg::CHAN_W-1:0] g,
                             logic [rca_pkg::CHAN_W-1:0] b,
                             logic [rca_pkg::CHAN_W-1:0] idx,
                             logic [rca_pkg::CHAN_W-1:0] val, logic fe);
        if (tx_gaps && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_cmd         <= cmd;
        s_red         <= r;
        s_green       <= g;
        s_blue        <= b;
        s_table_index <= idx;
        s_table_value <= val;
        s_frame_end   <= fe;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (cmd == rca_pkg::CMD_TABLE_WRITE) begin
            gamma_copy[idx] = val;
            if (!gamma_written[idx]) begin
                gamma_written[idx] = 1'b1;
                written_entries.push_back(idx);
            end
        end else begin
            pending_pixels.push_back(adjust_pixel(r, g, b, fe));
        end
    endtask

    // table fields of a pixel are don't-care, so they carry noise
    task automatic send_pixel(logic [rca_pkg::CHAN_W-1:0] r, logic [rca_pkg::CHAN_W-1:0] g,
                              logic [rca_pkg::CHAN_W-1:0] b, logic fe);
        send_item(rca_pkg::CMD_PIXEL, r, g, b, 8'($urandom), 8'($urandom), fe);
    endtask

    // pixel fields and frame end of a table write are ignored: send noise
    task automatic send_write(logic [rca_pkg::CHAN_W-1:0] idx,
                              logic [rca_pkg::CHAN_W-1:0] val);
        send_item(rca_pkg::CMD_TABLE_WRITE, 8'($urandom), 8'($urandom), 8'($urandom),
                  idx, val, 1'($urandom));
    endtask

    function automatic logic [rca_pkg::CHAN_W-1:0] pick_chan();
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return 8'(127 + $urandom_range(0, 2));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // gamma lookups stay on entries that have been written
    function automatic logic [rca_pkg::CHAN_W-1:0] pick_gamma_chan();
        return written_entries[$urandom_range(0, written_entries.size() - 1)];
    endfunction

    task automatic send_random_item();
        if ($urandom_range(0, 4) == 0) begin
            send_write(8'($urandom), 8'($urandom));
        end else if (cur_mode == rca_pkg::MODE_GAMMA) begin
            send_pixel(pick_gamma_chan(), pick_gamma_chan(), pick_gamma_chan(),
                       $urandom_range(0, 7) == 0);
        end else begin
            send_pixel(pick_chan(), pick_chan(), pick_chan(), $urandom_range(0, 7) == 0);
        end
    endtask

    // Drop valid and wait until every pending pixel has come out, then let the
    // tail of the queue (table writes) drain.
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write the selected registers, one per cycle, once the block is quiet.
    // Words are raw 12-bit values; only each register's low bits count.
    task automatic program_regs(bit [3:0] sel, logic [rca_pkg::CFG_DATA_W-1:0] w_mode,
                                logic [rca_pkg::CFG_DATA_W-1:0] w_offset,
                                logic [rca_pkg::CFG_DATA_W-1:0] w_gain,
                                logic [rca_pkg::CFG_DATA_W-1:0] w_level);
        logic [rca_pkg::CFG_DATA_W-1:0] words [4];
        words = '{w_mode, w_offset, w_gain, w_level};
        wait_drained();
        for (int i = 0; i < 4; i++) begin
            if (sel[i]) begin
                cfg_wr_en <= 1'b1;
                cfg_index <= rca_pkg::cfg_index_t'(i);
                cfg_wdata <= words[i];
                @(posedge aclk);
                case (rca_pkg::cfg_index_t'(i))
                    rca_pkg::CFG_MODE:       cur_mode   = words[i][2:0];
                    rca_pkg::CFG_BRIGHTNESS: cur_offset = words[i][rca_pkg::OFFSET_W-1:0];
                    rca_pkg::CFG_CONTRAST:   cur_gain   = words[i][rca_pkg::GAIN_W-1:0];
                    rca_pkg::CFG_THRESHOLD:  cur_level  = words[i][rca_pkg::CHAN_W-1:0];
                    default: ;
                endcase
            end
        end
        cfg_wr_en <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------------
    // Ready: a long hold-off on request, else random stall bursts when enabled.
    always @(posedge aclk) begin
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else if (stall_left != 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else if (rx_gaps && $urandom_range(0, 5) == 0) begin
            m_ready    <= 1'b0;
            stall_left = $urandom_range(0, 6);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Each output transfer is checked against the oldest pending pixel.
    always @(posedge aclk) begin
        adjusted_pixel_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_pixels.size() == 0) begin
                report_error($sformatf("result with nothing pending: %0d %0d %0d fe %0b",
                                       m_red_out, m_green_out, m_blue_out,
                                       m_frame_end_out));
            end else begin
                want = pending_pixels.pop_front();
                if (m_red_out !== want.red)
                    report_error($sformatf("red_out %0d, want %0d", m_red_out, want.red));
                if (m_green_out !== want.green)
                    report_error($sformatf("green_out %0d, want %0d",
                                           m_green_out, want.green));
                if (m_blue_out !== want.blue)
                    report_error($sformatf("blue_out %0d, want %0d", m_blue_out, want.blue));
                if (m_frame_end_out !== want.frame_end)
                    report_error($sformatf("frame_end_out %0b, want %0b",
                                           m_frame_end_out, want.frame_end));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Registers straight out of reset: offset 0, unity gain, level 128.
    task automatic test_reset_values();
        send_pixel(8'd255, 8'd0, 8'd77, 1'b0);
        // unity gain returns the pixel; upper word bits must be dropped
        program_regs(4'b0001, {9'h1F8, rca_pkg::MODE_CONTRAST}, '0, '0, '0);
        send_pixel(8'd0, 8'd255, 8'd128, 1'b0);
        send_pixel(8'd1, 8'd127, 8'd200, 1'b1);
        // mean exactly at the level gives white, one below gives black
        program_regs(4'b0001, {9'h000, rca_pkg::MODE_THRESHOLD}, '0, '0, '0);
        send_pixel(8'd128, 8'd128, 8'd128, 1'b0);
        send_pixel(8'd127, 8'd128, 8'd128, 1'b1);
    endtask

    // Each operation except gamma, at the extremes of its register where it has one.
    task automatic test_each_operation();
        program_regs(4'b0011, {9'($urandom), rca_pkg::MODE_BRIGHTNESS}, {3'b111, 9'd255},
                     '0, '0);
        send_pixel(8'd0, 8'd1, 8'd255, 1'b0);
        // offset -255
        program_regs(4'b0010, '0, {3'b000, 9'h101}, '0, '0);
        send_pixel(8'd255, 8'd254, 8'd0, 1'b1);
        // zero gain flattens everything to mid gray
        program_regs(4'b0101, {9'h0, rca_pkg::MODE_CONTRAST}, '0, 12'd0, '0);
        send_pixel(8'd0, 8'd128, 8'd255, 1'b0);
        program_regs(4'b0100, '0, '0, 12'hFFF, '0);
        send_pixel(8'd0, 8'd127, 8'd129, 1'b1);
        send_pixel(8'd255, 8'd128, 8'd130, 1'b0);
        program_regs(4'b0001, {9'h0, rca_pkg::MODE_GRAYSCALE}, '0, '0, '0);
        send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
        send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
        // sepia saturates on bright input
        program_regs(4'b0001, {9'h0, rca_pkg::MODE_SEPIA}, '0, '0, '0);
        send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
        send_pixel(8'd100, 8'd50, 8'd10, 1'b1);
        program_regs(4'b0001, {9'h0, rca_pkg::MODE_INVERT}, '0, '0, '0);
        send_pixel(8'd0, 8'd255, 8'd170, 1'b0);
        program_regs(4'b1001, {9'h0, rca_pkg::MODE_THRESHOLD}, '0, '0, {4'hF, 8'd0});
        send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
        program_regs(4'b1000, '0, '0, '0, {4'h0, 8'd255});
        send_pixel(8'd255, 8'd255, 8'd254, 1'b0);
        send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
        // unused mode: pass through
        program_regs(4'b0001, {9'h0, MODE_UNUSED}, '0, '0, '0);
        send_pixel(8'd12, 8'd34, 8'd56, 1'b1);
    endtask

    // Table writes ahead of lookups, and an overwrite right before a lookup.
    task automatic test_gamma_table();
        program_regs(4'b0001, {9'h0, rca_pkg::MODE_GAMMA}, '0, '0, '0);
        send_write(8'd0, 8'hFF);
        send_write(8'd255, 8'h00);
        send_write(8'd128, 8'hA5);
        send_pixel(8'd0, 8'd255, 8'd128, 1'b1);
        send_write(8'd128, 8'h5A);
        send_pixel(8'd128, 8'd0, 8'd128, 1'b0);
    endtask

    // Receiver holds off while the sender streams back to back: the queue
    // fills and s_ready drops. Then the sender pauses until all results are
    // out before it goes on.
    task automatic test_fill_and_stall();
        program_regs(4'b0001, {9'h0, rca_pkg::MODE_SEPIA}, '0, '0, '0);
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        @(negedge aclk);
        hold_request = 60;
        @(posedge aclk);
        repeat (30) send_random_item();
        wait_drained();
        repeat (20) send_random_item();
    endtask

    // Random phases, each with its own register setting. Idle bursts on both
    // sides except in every fifth phase and in the closing phases.
    task automatic test_random_traffic();
        logic [2:0]                   mode_sel;
        logic [rca_pkg::OFFSET_W-1:0] offset;
        logic [rca_pkg::GAIN_W-1:0]   gain;
        logic [rca_pkg::CHAN_W-1:0]   level;
        for (int phase = 0; phase < 28; phase++) begin
            mode_sel = 3'($urandom_range(0, 7));
            case ($urandom_range(0, 3))
                0:       offset = 9'h101;
                1:       offset = 9'd255;
                default: offset = 9'($urandom_range(0, 510) - 255);
            endcase
            case ($urandom_range(0, 3))
                0:       gain = 12'd0;
                1:       gain = 12'hFFF;
                default: gain = 12'($urandom);
            endcase
            case ($urandom_range(0, 3))
                0:       level = 8'd0;
                1:       level = 8'd255;
                default: level = 8'($urandom);
            endcase
            program_regs(4'hF, {9'($urandom), mode_sel}, {3'($urandom), offset}, gain,
                         {4'($urandom), level});
            tx_gaps = (phase < 22) && (phase % 5 != 4);
            rx_gaps = tx_gaps;
            repeat (50) send_random_item();
        end
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        wait_drained();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        aclk          = 1'b0;
        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = rca_pkg::CFG_MODE;
        cfg_wdata     = '0;
        s_valid       = 1'b0;
        s_cmd         = rca_pkg::CMD_PIXEL;
        s_red         = '0;
        s_green       = '0;
        s_blue        = '0;
        s_table_index = '0;
        s_table_value = '0;
        s_frame_end   = 1'b0;
        m_ready       = 1'b0;
        tx_gaps       = 1'b1;
        rx_gaps       = 1'b1;
        hold_request  = 0;
        hold_left     = 0;
        stall_left    = 0;
        mismatches    = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_values();
        test_each_operation();
        test_gamma_table();
        test_fill_and_stall();
        test_random_traffic();

        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run (~1.5k items with worst
    // idle bursts on both sides, the hold-off and every drain).
    initial begin
        #1000000;
        $display("FAIL");
        $finish;
    end

endmodule
